// ----- rtl/chained_block_directory_allocator_macros.svh -----
// Assertion helpers for the chained block directory allocator.
`ifndef CHAINED_BLOCK_DIRECTORY_ALLOCATOR_MACROS_SVH
`define CHAINED_BLOCK_DIRECTORY_ALLOCATOR_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define CBDA_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked in the cycle after the antecedent.
`define CBDA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/cbda_pkg.sv -----
// ----------------------------------------------------------------------------
// Chained block directory allocator package
// Commands, status codes, entry state codes and field widths.
// ----------------------------------------------------------------------------
package cbda_pkg;

   localparam int DEF_ENTRIES = 15;

   localparam int REQ_DATA_W = 40;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 3;

   typedef enum logic [2:0] {
      CMD_FORMAT   = 3'd0,
      CMD_WRITE    = 3'd1,
      CMD_READ     = 3'd2,
      CMD_ALLOCATE = 3'd3,
      CMD_DELETE   = 3'd4,
      CMD_UNDELETE = 3'd5,
      CMD_COUNT    = 3'd6,
      CMD_QUERY    = 3'd7
   } command_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_EMPTY        = 3'd1,
      ST_NO_SPACE     = 3'd2,
      ST_NOT_DELETED  = 3'd3,
      ST_BAD_STATE    = 3'd4,
      ST_NOT_LISTED   = 3'd5,
      ST_BROKEN_CHAIN = 3'd6,
      ST_BAD_INDEX    = 3'd7
   } status_type;

   localparam logic [7:0] STATE_MASK  = 8'hF0;
   localparam logic [7:0] STATE_FREE  = 8'hA0;
   localparam logic [7:0] STATE_FIRST = 8'h51;
   localparam logic [7:0] STATE_MID   = 8'h52;
   localparam logic [7:0] STATE_FIN   = 8'h53;
   localparam logic [7:0] DEL_FIRST   = 8'hA1;
   localparam logic [7:0] DEL_MID     = 8'hA2;
   localparam logic [7:0] DEL_FIN     = 8'hA3;
   localparam logic [15:0] LINK_END   = 16'hFFFF;

   // Code by position in a chain: first wins over final.
   function automatic logic [7:0] pos_code(input logic [3:0] pos, input logic [3:0] cnt,
                                           input logic [7:0] first, input logic [7:0] mid,
                                           input logic [7:0] fin);
      logic [7:0] code;
      if (pos == 4'd0) code = first;
      else if (pos == cnt - 4'd1) code = fin;
      else code = mid;
      return code;
   endfunction

endpackage

// ----- rtl/chained_block_directory_allocator.sv -----
// ----------------------------------------------------------------------------
// Chained block directory allocator
// Block directory with chain allocate, delete, undelete and query commands.
// ----------------------------------------------------------------------------
// Each command item is taken only while the sequencer is idle and then runs
// through one directory port, one entry per cycle while it is not waiting to
// hand over a result item: a format sweeps all ENTRIES entries, an allocate
// scans the directory once from the bottom and relinks the previous entry in
// an extra step for each block after the first, a delete or a query walks at
// most ENTRIES links, and an undelete walks its chain twice. A new result is
// loaded once the previous one is taken. The free count is kept as a running
// counter, so count free does not scan the directory.
`include "chained_block_directory_allocator_macros.svh"

module chained_block_directory_allocator #(
   parameter int ENTRIES = cbda_pkg::DEF_ENTRIES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // tdata, low bit up: block[3:0], block_count[7:4], clear_entries[8],
   // file_deleted[9], show_deleted[10], entry_state_in[18:11],
   // entry_link_in[34:19], zero fill.
   input  logic [cbda_pkg::REQ_DATA_W-1:0] req_tdata,
   // tuser: command[2:0].
   input  logic [cbda_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // tdata, low bit up: block_out[3:0], free_count[7:4], chain_length[11:8],
   // is_deleted[12], entry_state_out[20:13], entry_link_out[36:21], zero fill.
   output logic [cbda_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // tuser: status[2:0].
   output logic [cbda_pkg::RSP_USER_W-1:0] rsp_tuser,
   output logic                            rsp_tlast
);
   import cbda_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int LEN_W = $clog2(ENTRIES + 2);
   localparam logic [15:0] ENT16 = 16'(ENTRIES);

   typedef enum logic [3:0] {
      S_IDLE, S_FORMAT, S_ALLOC_SCAN, S_ALLOC_LINK, S_WALK_DEL,
      S_WALK_CHK, S_WALK_RST, S_QUERY, S_EMIT
   } seq_type;

   // Directory storage.
   logic [7:0]  dir_state [ENTRIES];
   logic [15:0] dir_link  [ENTRIES];

   seq_type          seq_ff;
   logic [3:0]       blk_ff, cnt_ff, step_ff;
   logic             clr_ff;
   logic [IDX_W-1:0] cur_ff, prev_ff, new_ff;
   logic             have_prev_ff;
   logic [LEN_W-1:0] len_ff;
   logic [3:0]       free_ff, fin_free_ff;
   logic             use_fin_ff;

   // Staged result item.
   logic [2:0]  res_status_ff;
   logic [3:0]  res_block_ff, res_len_ff;
   logic        res_del_ff, res_last_ff;
   logic [7:0]  res_st_ff;
   logic [15:0] res_lk_ff;

   // Result output register.
   logic        rsp_valid_ff;
   logic [2:0]  out_status_ff;
   logic [3:0]  out_block_ff, out_free_ff, out_len_ff;
   logic        out_del_ff, out_last_ff;
   logic [7:0]  out_st_ff;
   logic [15:0] out_lk_ff;

   // Input field unpacking.
   command_type req_cmd;
   logic [3:0]  req_blk, req_cnt;
   logic        req_clr, req_fdel, req_incl;
   logic [7:0]  req_sin;
   logic [15:0] req_lin;
   assign req_cmd  = command_type'(req_tuser[2:0]);
   assign req_blk  = req_tdata[3:0];
   assign req_cnt  = req_tdata[7:4];
   assign req_clr  = req_tdata[8];
   assign req_fdel = req_tdata[9];
   assign req_incl = req_tdata[10];
   assign req_sin  = req_tdata[18:11];
   assign req_lin  = req_tdata[34:19];

   logic             req_fire, req_blk_ok;
   logic [3:0]       req_blk_m1;
   logic [IDX_W-1:0] req_idx;
   assign req_tready = (seq_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_blk_ok = (req_blk != 4'd0) && ({12'd0, req_blk} <= ENT16);
   assign req_blk_m1 = req_blk - 4'd1;
   assign req_idx    = req_blk_m1[IDX_W-1:0];

   // Single directory port: one read address, one write.
   logic [IDX_W-1:0] rd_idx, wr_idx;
   logic [7:0]       rd_state, wr_state;
   logic [15:0]      rd_link, wr_link;
   logic             wr_state_en, wr_link_en;

   assign rd_idx = (seq_ff == S_IDLE) ? req_idx : cur_ff;

   always_comb begin
      rd_state = 8'd0;
      rd_link  = 16'd0;
      if ({{(32-IDX_W){1'b0}}, rd_idx} < ENTRIES) begin
         rd_state = dir_state[rd_idx];
         rd_link  = dir_link[rd_idx];
      end
   end

   logic        rd_free, link_ok, more;
   logic [3:0]  step_nx;
   logic [IDX_W-1:0] link_idx;
   assign rd_free  = (rd_state & STATE_MASK) == STATE_FREE;
   assign link_ok  = rd_link < ENT16;
   assign link_idx = rd_link[IDX_W-1:0];
   assign step_nx  = step_ff + 4'd1;
   assign more     = (step_nx < cnt_ff) && link_ok;

   // Write port control per sequencer step.
   always_comb begin
      wr_idx      = rd_idx;
      wr_state    = rd_state;
      wr_link     = rd_link;
      wr_state_en = 1'b0;
      wr_link_en  = 1'b0;
      case (seq_ff)
         S_IDLE: begin
            if (req_fire && req_cmd == CMD_WRITE && req_blk_ok) begin
               wr_state    = req_sin;
               wr_link     = req_lin;
               wr_state_en = 1'b1;
               wr_link_en  = 1'b1;
            end
         end
         S_FORMAT: begin
            wr_state    = STATE_FREE;
            wr_link     = LINK_END;
            wr_state_en = 1'b1;
            wr_link_en  = 1'b1;
         end
         S_ALLOC_SCAN: begin
            if (rd_free) begin
               wr_state    = pos_code(step_ff, cnt_ff, STATE_FIRST, STATE_MID, STATE_FIN);
               wr_link     = LINK_END;
               wr_state_en = 1'b1;
               wr_link_en  = 1'b1;
            end
         end
         S_ALLOC_LINK: begin
            wr_idx     = prev_ff;
            wr_link    = 16'(new_ff);
            wr_link_en = 1'b1;
         end
         S_WALK_DEL: begin
            wr_state    = clr_ff ? STATE_FREE
                                 : pos_code(step_ff, cnt_ff, DEL_FIRST, DEL_MID, DEL_FIN);
            wr_link     = LINK_END;
            wr_state_en = 1'b1;
            wr_link_en  = 1'b1;
         end
         S_WALK_RST: begin
            wr_state    = pos_code(step_ff, cnt_ff, STATE_FIRST, STATE_MID, STATE_FIN);
            wr_state_en = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Directory write; reset leaves every entry free with an ended link.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            dir_state[i] <= STATE_FREE;
            dir_link[i]  <= LINK_END;
         end
      end else begin
         if (wr_state_en) dir_state[wr_idx] <= wr_state;
         if (wr_link_en)  dir_link[wr_idx]  <= wr_link;
      end
   end

   // Running free count: each state write replaces the value read at its address.
   logic new_free;
   logic [3:0] free_in;
   assign new_free = (wr_state & STATE_MASK) == STATE_FREE;
   always_comb begin
      free_in = free_ff;
      if (wr_state_en) free_in = free_ff + {3'd0, new_free} - {3'd0, rd_free};
   end

   logic emit_load;
   assign emit_load = (seq_ff == S_EMIT) && (!rsp_valid_ff || rsp_tready);

   // Sequencer and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= S_IDLE;
         free_ff      <= 4'(ENTRIES);
         rsp_valid_ff <= 1'b0;
      end else begin
         free_ff <= free_in;
         if (rsp_tready && !emit_load) rsp_valid_ff <= 1'b0;
         case (seq_ff)
            S_IDLE: begin
               if (req_fire) begin
                  blk_ff        <= req_blk;
                  cnt_ff        <= req_cnt;
                  clr_ff        <= req_clr;
                  step_ff       <= 4'd0;
                  cur_ff        <= req_idx;
                  have_prev_ff  <= 1'b0;
                  use_fin_ff    <= 1'b0;
                  res_status_ff <= ST_OK;
                  res_block_ff  <= 4'd0;
                  res_len_ff    <= 4'd0;
                  res_del_ff    <= 1'b0;
                  res_st_ff     <= 8'd0;
                  res_lk_ff     <= 16'd0;
                  res_last_ff   <= 1'b1;
                  seq_ff        <= S_EMIT;
                  case (req_cmd)
                     CMD_FORMAT: begin
                        cur_ff <= '0;
                        seq_ff <= S_FORMAT;
                     end
                     CMD_WRITE: begin
                        if (!req_blk_ok) res_status_ff <= ST_BAD_INDEX;
                     end
                     CMD_READ: begin
                        if (!req_blk_ok) res_status_ff <= ST_BAD_INDEX;
                        else begin
                           res_st_ff <= rd_state;
                           res_lk_ff <= rd_link;
                        end
                     end
                     CMD_ALLOCATE: begin
                        if (req_cnt == 4'd0) res_status_ff <= ST_EMPTY;
                        else if (free_ff < req_cnt) res_status_ff <= ST_NO_SPACE;
                        else begin
                           fin_free_ff <= free_ff - req_cnt;
                           use_fin_ff  <= 1'b1;
                           cur_ff      <= '0;
                           seq_ff      <= S_ALLOC_SCAN;
                        end
                     end
                     CMD_DELETE: begin
                        if (!req_blk_ok) res_status_ff <= ST_BAD_INDEX;
                        else if (req_cnt != 4'd0) seq_ff <= S_WALK_DEL;
                     end
                     CMD_UNDELETE: begin
                        if (!req_fdel) res_status_ff <= ST_NOT_DELETED;
                        else if (!req_blk_ok) res_status_ff <= ST_BAD_INDEX;
                        else if (req_cnt != 4'd0) seq_ff <= S_WALK_CHK;
                     end
                     CMD_COUNT: begin
                     end
                     default: begin
                        if (!req_blk_ok) res_status_ff <= ST_BAD_INDEX;
                        else if (!(rd_state == STATE_FIRST ||
                                   (req_incl && (rd_state == DEL_FIRST ||
                                    rd_state == DEL_MID || rd_state == DEL_FIN))))
                           res_status_ff <= ST_NOT_LISTED;
                        else begin
                           res_del_ff <= rd_state != STATE_FIRST;
                           len_ff     <= LEN_W'(1);
                           seq_ff     <= S_QUERY;
                        end
                     end
                  endcase
               end
            end
            S_FORMAT: begin
               cur_ff <= cur_ff + 1'b1;
               if ({{(32-IDX_W){1'b0}}, cur_ff} == ENTRIES - 1) seq_ff <= S_EMIT;
            end
            S_ALLOC_SCAN: begin
               cur_ff <= cur_ff + 1'b1;
               if (rd_free) begin
                  new_ff       <= cur_ff;
                  res_block_ff <= 4'(cur_ff) + 4'd1;
                  res_last_ff  <= step_ff == cnt_ff - 4'd1;
                  if (have_prev_ff) seq_ff <= S_ALLOC_LINK;
                  else begin
                     prev_ff      <= cur_ff;
                     have_prev_ff <= 1'b1;
                     seq_ff       <= S_EMIT;
                  end
               end
            end
            S_ALLOC_LINK: begin
               prev_ff <= new_ff;
               seq_ff  <= S_EMIT;
            end
            S_WALK_DEL: begin
               step_ff <= step_nx;
               cur_ff  <= link_idx;
               if (!more) seq_ff <= S_EMIT;
            end
            S_WALK_CHK: begin
               if (rd_state != pos_code(step_ff, cnt_ff, DEL_FIRST, DEL_MID, DEL_FIN)) begin
                  res_status_ff <= ST_BAD_STATE;
                  seq_ff        <= S_EMIT;
               end else if (!more) begin
                  step_ff <= 4'd0;
                  cur_ff  <= IDX_W'(blk_ff - 4'd1);
                  seq_ff  <= S_WALK_RST;
               end else begin
                  step_ff <= step_nx;
                  cur_ff  <= link_idx;
               end
            end
            S_WALK_RST: begin
               step_ff <= step_nx;
               cur_ff  <= link_idx;
               if (!more) seq_ff <= S_EMIT;
            end
            S_QUERY: begin
               if (link_ok && len_ff < LEN_W'(ENTRIES + 1)) begin
                  len_ff <= len_ff + 1'b1;
                  cur_ff <= link_idx;
               end else if (len_ff == LEN_W'(ENTRIES + 1)) begin
                  res_status_ff <= ST_BROKEN_CHAIN;
                  res_del_ff    <= 1'b0;
                  seq_ff        <= S_EMIT;
               end else begin
                  res_len_ff <= 4'(len_ff);
                  seq_ff     <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (emit_load) begin
                  rsp_valid_ff  <= 1'b1;
                  out_status_ff <= res_status_ff;
                  out_block_ff  <= res_block_ff;
                  out_free_ff   <= use_fin_ff ? fin_free_ff : free_ff;
                  out_len_ff    <= res_len_ff;
                  out_del_ff    <= res_del_ff;
                  out_st_ff     <= res_st_ff;
                  out_lk_ff     <= res_lk_ff;
                  out_last_ff   <= res_last_ff;
                  if (res_last_ff) seq_ff <= S_IDLE;
                  else begin
                     step_ff <= step_nx;
                     seq_ff  <= S_ALLOC_SCAN;
                  end
               end
            end
            default: seq_ff <= S_IDLE;
         endcase
      end
   end

   // Output packing.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {3'd0, out_lk_ff, out_st_ff, out_del_ff, out_len_ff,
                        out_free_ff, out_block_ff};

   // Checks on the sequencer and the free counter.
   `CBDA_ASSERT_IMPL(a_free_range, 1'b1, {28'd0, free_ff} <= ENTRIES, "free count exceeds depth")
   `CBDA_ASSERT_NEXT(a_busy_after_accept, req_fire, !req_tready, "ready right after accept")
   `CBDA_ASSERT_IMPL(a_load_slot, emit_load, !rsp_valid_ff || rsp_tready, "result overwritten")
   `CBDA_ASSERT_IMPL(a_alloc_link_prev, seq_ff == S_ALLOC_LINK, have_prev_ff, "relink without prev")

endmodule

// ----- sim/chained_block_directory_allocator_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Chained block directory allocator testbench
// Sends directed and random command items and keeps its own model of the
// 15-entry directory. Every result item is checked, field by field, against
// the oldest expected result.
// ----------------------------------------------------------------------------
module chained_block_directory_allocator_test;
   import cbda_pkg::*;

   localparam int NUM_ENTRIES = DEF_ENTRIES;
   localparam int DRAIN_CYCLES = 2 * NUM_ENTRIES + 20;

   typedef struct {
      status_type  status;
      logic [3:0]  block_out;
      logic [3:0]  free_count;
      logic [3:0]  chain_length;
      logic        is_deleted;
      logic [7:0]  entry_state;
      logic [15:0] entry_link;
      logic        last;
   } result_item;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // tdata, low bit up: block, block_count, clear_entries, file_deleted,
   // show_deleted, entry_state_in, entry_link_in, zero fill.
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // tuser: command.
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // tdata, low bit up: block_out, free_count, chain_length, is_deleted,
   // entry_state_out, entry_link_out, zero fill.
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // tuser: status.
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tlast;

   // Directory copy kept by the testbench, indexed by block number.
   logic [7:0]  dir_state [1:NUM_ENTRIES];
   logic [15:0] dir_link  [1:NUM_ENTRIES];
   result_item  expected_results [$];
   int          error_count = 0;
   int          sender_idle_pct = 0;
   int          receiver_stall_pct = 0;
   int          chain_head = 1;
   int          chain_len = 1;

   chained_block_directory_allocator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // Receiver stalls at random while a stall rate is set.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) < receiver_stall_pct) ? 1'b0 : 1'b1;
   end

   function automatic int free_entries();
      int n;
      n = 0;
      for (int i = 1; i <= NUM_ENTRIES; i++)
         if ((dir_state[i] & STATE_MASK) == STATE_FREE) n++;
      return n;
   endfunction

   function automatic logic [7:0] chain_code(int pos, int cnt, logic [7:0] first,
                                             logic [7:0] mid, logic [7:0] fin);
      if (pos == 0) return first;
      if (pos == cnt - 1) return fin;
      return mid;
   endfunction

   task automatic format_directory();
      for (int i = 1; i <= NUM_ENTRIES; i++) begin
         dir_state[i] = STATE_FREE;
         dir_link[i] = LINK_END;
      end
   endtask

   // Applies one command to the directory copy and queues its results.
   task automatic predict_command(command_type cmd, int blk, int cnt, logic clr,
                                  logic fdel, logic incl, logic [7:0] sin,
                                  logic [15:0] lin);
      result_item r;
      result_item batch [$];
      int b, e, prev, len, fc;
      logic ok;
      logic [7:0] s;
      r.status = ST_OK;
      r.block_out = 0;
      r.free_count = 0;
      r.chain_length = 0;
      r.is_deleted = 0;
      r.entry_state = 0;
      r.entry_link = 0;
      r.last = 0;
      case (cmd)
         CMD_FORMAT: begin
            format_directory();
            batch = {batch, r};
         end
         CMD_WRITE: begin
            if (blk < 1 || blk > NUM_ENTRIES) r.status = ST_BAD_INDEX;
            else begin
               dir_state[blk] = sin;
               dir_link[blk] = lin;
            end
            batch = {batch, r};
         end
         CMD_READ: begin
            if (blk < 1 || blk > NUM_ENTRIES) r.status = ST_BAD_INDEX;
            else begin
               r.entry_state = dir_state[blk];
               r.entry_link = dir_link[blk];
            end
            batch = {batch, r};
         end
         CMD_ALLOCATE: begin
            if (cnt == 0) begin
               r.status = ST_EMPTY;
               batch = {batch, r};
            end else if (free_entries() < cnt) begin
               r.status = ST_NO_SPACE;
               batch = {batch, r};
            end else begin
               prev = 0;
               for (int i = 0; i < cnt; i++) begin
                  b = 0;
                  for (int j = NUM_ENTRIES; j >= 1; j--)
                     if ((dir_state[j] & STATE_MASK) == STATE_FREE) b = j;
                  if (prev != 0) begin
                     dir_link[prev] = b - 1;
                     dir_state[b] = (i == cnt - 1) ? STATE_FIN : STATE_MID;
                  end else begin
                     dir_state[b] = STATE_FIRST;
                     chain_head = b;
                     chain_len = cnt;
                  end
                  dir_link[b] = LINK_END;
                  prev = b;
                  r.block_out = b;
                  batch = {batch, r};
               end
            end
         end
         CMD_DELETE: begin
            if (blk < 1 || blk > NUM_ENTRIES) r.status = ST_BAD_INDEX;
            else begin
               b = blk;
               for (int i = 0; i < cnt && b >= 1 && b <= NUM_ENTRIES; i++) begin
                  e = b;
                  b = int'(dir_link[e]) + 1;
                  dir_state[e] = clr ? STATE_FREE
                                     : chain_code(i, cnt, DEL_FIRST, DEL_MID, DEL_FIN);
                  dir_link[e] = LINK_END;
               end
            end
            batch = {batch, r};
         end
         CMD_UNDELETE: begin
            if (!fdel) r.status = ST_NOT_DELETED;
            else if (blk < 1 || blk > NUM_ENTRIES) r.status = ST_BAD_INDEX;
            else begin
               // Check every mark first, then restore the chain.
               ok = 1'b1;
               b = blk;
               for (int i = 0; i < cnt && b >= 1 && b <= NUM_ENTRIES && ok; i++) begin
                  e = b;
                  b = int'(dir_link[e]) + 1;
                  if (dir_state[e] != chain_code(i, cnt, DEL_FIRST, DEL_MID, DEL_FIN))
                     ok = 1'b0;
               end
               if (!ok) r.status = ST_BAD_STATE;
               else begin
                  b = blk;
                  for (int i = 0; i < cnt && b >= 1 && b <= NUM_ENTRIES; i++) begin
                     e = b;
                     b = int'(dir_link[e]) + 1;
                     dir_state[e] = chain_code(i, cnt, STATE_FIRST, STATE_MID, STATE_FIN);
                  end
               end
            end
            batch = {batch, r};
         end
         CMD_COUNT: batch = {batch, r};
         default: begin
            if (blk < 1 || blk > NUM_ENTRIES) r.status = ST_BAD_INDEX;
            else begin
               s = dir_state[blk];
               if (!(s == STATE_FIRST ||
                     (incl && (s == DEL_FIRST || s == DEL_MID || s == DEL_FIN))))
                  r.status = ST_NOT_LISTED;
               else begin
                  // Follow links; a chain longer than the directory is a loop.
                  len = 1;
                  e = blk;
                  while (dir_link[e] < NUM_ENTRIES && len < NUM_ENTRIES + 1) begin
                     len++;
                     e = int'(dir_link[e]) + 1;
                  end
                  if (len == NUM_ENTRIES + 1) r.status = ST_BROKEN_CHAIN;
                  else begin
                     r.chain_length = len;
                     r.is_deleted = (s != STATE_FIRST);
                  end
               end
            end
            batch = {batch, r};
         end
      endcase
      fc = free_entries();
      foreach (batch[k]) begin
         batch[k].free_count = fc;
         batch[k].last = (k == batch.size() - 1);
         expected_results = {expected_results, batch[k]};
      end
   endtask

   // Sends one command item and predicts its results once it is taken.
   task automatic send_command(command_type cmd, int blk = 0, int cnt = 0,
                               logic clr = 0, logic fdel = 0, logic incl = 0,
                               logic [7:0] sin = 0, logic [15:0] lin = 0);
      while ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {5'b0, lin, sin, incl, fdel, clr, 4'(cnt), 4'(blk)};
      do @(posedge clock); while (!req_tready);
      predict_command(cmd, blk, cnt, clr, fdel, incl, sin, lin);
   endtask

   // Holds the sender off until every expected result has arrived.
   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
         error_count++;
      end
   endtask

   // Result checker: each taken item is matched with the oldest expectation.
   always @(posedge clock) begin
      result_item x;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $error("result item with no expected result, tdata 0x%0h", rsp_tdata);
            error_count++;
         end else begin
            x = expected_results.pop_front();
            compare_field("status", x.status, rsp_tuser);
            compare_field("block_out", x.block_out, rsp_tdata[3:0]);
            compare_field("free_count", x.free_count, rsp_tdata[7:4]);
            compare_field("chain_length", x.chain_length, rsp_tdata[11:8]);
            compare_field("is_deleted", x.is_deleted, rsp_tdata[12]);
            compare_field("entry_state_out", x.entry_state, rsp_tdata[20:13]);
            compare_field("entry_link_out", x.entry_link, rsp_tdata[36:21]);
            compare_field("zero_fill", 16'h0, 16'(rsp_tdata[39:37]));
            compare_field("last", x.last, rsp_tlast);
         end
      end
   end

   // Field extremes, every command and each error case.
   task automatic test_directed();
      send_command(CMD_COUNT);
      send_command(CMD_WRITE, 0, 15, 1, 1, 1, 8'hFF, 16'hFFFF);
      send_command(CMD_READ, 0);
      send_command(CMD_QUERY, 0, 0, 0, 0, 1);
      send_command(CMD_DELETE, 0, 3);
      send_command(CMD_UNDELETE, 0, 3, 0, 1);
      send_command(CMD_UNDELETE, 3, 3, 0, 0);
      send_command(CMD_ALLOCATE, 0, 0);
      send_command(CMD_ALLOCATE, 0, 15);
      send_command(CMD_ALLOCATE, 0, 1);
      send_command(CMD_QUERY, 1, 0, 0, 0, 0);
      send_command(CMD_DELETE, 1, 15, 0);
      send_command(CMD_QUERY, 1, 0, 0, 0, 0);
      send_command(CMD_QUERY, 1, 0, 0, 0, 1);
      send_command(CMD_UNDELETE, 2, 14, 0, 1);
      send_command(CMD_UNDELETE, 1, 15, 0, 1);
      send_command(CMD_DELETE, 1, 15, 1);
      send_command(CMD_WRITE, 15, 0, 0, 0, 0, STATE_FIRST, 16'd14);
      send_command(CMD_QUERY, 15);
      send_command(CMD_WRITE, 15, 0, 0, 0, 0, 8'h00, 16'h0000);
      send_command(CMD_READ, 15);
      send_command(CMD_WRITE, 2, 0, 0, 0, 0, DEL_MID, 16'd1);
      send_command(CMD_QUERY, 2, 0, 0, 0, 1);
      send_command(CMD_FORMAT);
      send_command(CMD_READ, 2);
   endtask

   // Well-formed file sequences on the most recent chain.
   task automatic test_file_sequences(int rounds);
      int head, len;
      for (int n = 0; n < rounds; n++) begin
         send_command(CMD_ALLOCATE, 0, $urandom_range(5, 1));
         head = chain_head;
         len = chain_len;
         send_command(CMD_QUERY, head, 0, 0, 0, $urandom_range(1));
         send_command(CMD_DELETE, head, len, $urandom_range(99) < 25);
         send_command(CMD_UNDELETE, head, len, 0, $urandom_range(99) < 90);
         if ($urandom_range(3) == 0)
            send_command(CMD_READ, $urandom_range(NUM_ENTRIES, 1));
         if ($urandom_range(4) == 0) send_command(CMD_DELETE, head, len, 1);
      end
   endtask

   // Random commands with random fields, biased toward live chains.
   task automatic test_random_commands(int count);
      command_type cmd;
      int blk, cnt;
      for (int n = 0; n < count; n++) begin
         cmd = command_type'($urandom_range(7));
         if ($urandom_range(99) < 60) begin
            blk = chain_head;
            cnt = chain_len;
         end else begin
            blk = $urandom_range(15);
            cnt = $urandom_range(15);
         end
         if (cmd == CMD_ALLOCATE && $urandom_range(99) < 80) cnt = $urandom_range(4);
         if (cmd == CMD_FORMAT && $urandom_range(1)) cmd = CMD_COUNT;
         send_command(cmd, blk, cnt, $urandom_range(1), $urandom_range(1),
                      $urandom_range(1), $urandom_range(255), $urandom_range(65535));
      end
   endtask

   initial begin
      format_directory();
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      wait_for_results();
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 68; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 68; end
            default: begin sender_idle_pct = 7; receiver_stall_pct = 7; end
         endcase
         test_file_sequences(8);
         test_random_commands(35);
         wait_for_results();
      end
      if (error_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   // Run limit well beyond the slowest correct run.
   initial begin
      #5000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/cbda_pkg.sv
rtl/chained_block_directory_allocator.sv
sim/chained_block_directory_allocator_test.sv
